### rtl/core/rkspe_pkg.sv
// Shared types and constants of the Runge-Kutta stability polynomial evaluator.
package rkspe_pkg;

  localparam int MAX_STAGES = 16;
  localparam int STG_W      = $clog2(MAX_STAGES);
  localparam int CNT_W      = $clog2(MAX_STAGES + 1);
  localparam int TBL_DEPTH  = MAX_STAGES * MAX_STAGES;
  localparam int TBL_AW     = $clog2(TBL_DEPTH);

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_REAL = 2'd1;
  localparam logic [1:0] REQ_CPLX = 2'd2;

  localparam logic signed [63:0] Q24_ONE = 64'sd16777216;
  localparam logic [47:0] S48_MAX = {1'b0, {47{1'b1}}};
  localparam logic [47:0] S48_MIN = {1'b1, {47{1'b0}}};

  typedef struct packed {
    logic [1:0]         req_type;
    logic [3:0]         coef_row;
    logic [3:0]         coef_col;
    logic signed [31:0] coef_value;
    logic signed [31:0] z_real;
    logic signed [31:0] z_imag;
  } in_t;

  typedef struct packed {
    logic signed [47:0] result_value;
    logic               saturated;
  } out_t;

endpackage

### rtl/core/rkspe_ram.sv
// Generic single write port RAM with a registered read port.
module rkspe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/rk_stability_polynomial_eval_top.sv
// Top level of the Runge-Kutta stability polynomial evaluator.
// A load item writes one Q2.30 coefficient into a 256-entry table RAM and
// returns nothing; coefficients must be loaded before an evaluation reads them. An
// evaluation item runs the stage recursion on one shared 32 x 25 bit multiplier: every
// coefficient or z product passes through two half products, a combine and an
// accumulate, and a complex point adds a sum of squares and a 48-step bitwise square root.
// The input is not ready while an evaluation runs; a finished result waits in the output
// register, and the next item is taken meanwhile.
module rk_stability_polynomial_eval_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [4:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  rkspe_pkg::in_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rkspe_pkg::out_t   out_data
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_START = 4'd1;
  localparam logic [3:0] ST_CRD   = 4'd2;
  localparam logic [3:0] ST_CLAT  = 4'd3;
  localparam logic [3:0] ST_P0    = 4'd4;
  localparam logic [3:0] ST_P1    = 4'd5;
  localparam logic [3:0] ST_P2    = 4'd6;
  localparam logic [3:0] ST_P3    = 4'd7;
  localparam logic [3:0] ST_SAT   = 4'd8;
  localparam logic [3:0] ST_ZWR   = 4'd9;
  localparam logic [3:0] ST_RHO   = 4'd10;
  localparam logic [3:0] ST_SQM   = 4'd11;
  localparam logic [3:0] ST_SQA   = 4'd12;
  localparam logic [3:0] ST_SQRT  = 4'd13;
  localparam logic [3:0] ST_DONE  = 4'd14;

  localparam logic MODE_COEF = 1'b0;
  localparam logic MODE_Z    = 1'b1;

  localparam int CW = rkspe_pkg::CNT_W;
  localparam int SW = rkspe_pkg::STG_W;
  localparam int AW = rkspe_pkg::TBL_AW;
  localparam int MS = rkspe_pkg::MAX_STAGES;

  function automatic logic [48:0] sat48(input logic signed [63:0] x);
    logic ovf;
    logic [47:0] v;
    ovf = !((&x[63:47]) || !(|x[63:47]));
    v = ovf ? (x[63] ? rkspe_pkg::S48_MIN : rkspe_pkg::S48_MAX) : x[47:0];
    return {ovf, v};
  endfunction

  logic [3:0]         state_r, state_nxt;
  logic               cplx_r, cplx_nxt;
  logic               rho_r, rho_nxt;
  logic               mode_r, mode_nxt;
  logic [2:0]         part_r, part_nxt;
  logic [CW-1:0]      k_r, k_nxt, i_r, i_nxt, s_r, s_nxt;
  logic signed [31:0] zr_r, zr_nxt, zi_r, zi_nxt, c_r, c_nxt;
  logic signed [47:0] tr_r, tr_nxt, ti_r, ti_nxt;
  logic signed [63:0] acc_r, acc_nxt, aci_r, aci_nxt;
  logic signed [56:0] prod_r, prod_nxt, lo_r, lo_nxt;
  logic signed [79:0] sum_r, sum_nxt;
  logic signed [96:0] sq_r, sq_nxt;
  logic [51:0]        rem_r, rem_nxt;
  logic [47:0]        root_r, root_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic               flag_r, flag_nxt;
  logic [4:0]         stage_cnt_r;
  logic               out_valid_r, out_valid_nxt;
  rkspe_pkg::out_t    out_data_r, out_data_nxt;

  logic signed [47:0] yr_r [MS];
  logic signed [47:0] yi_r [MS];
  logic               y_we;
  logic [SW-1:0]      y_wa;
  logic signed [47:0] y_wdr, y_wdi;

  logic               tbl_we;
  logic [AW-1:0]      tbl_waddr, tbl_raddr;
  logic [31:0]        tbl_rdata;
  logic [CW-1:0]      col_v;

  logic signed [31:0] job_a, mul_a;
  logic signed [47:0] job_b, sqv;
  logic signed [24:0] mul_b;
  logic signed [56:0] mul_p;
  logic               job_neg, job_dst, job_sh30;
  logic signed [79:0] sh_v;
  logic signed [63:0] term;
  logic signed [96:0] sq_ext, sq_add;
  logic [51:0]        rem_sh, trial;
  logic               ge;
  logic [48:0]        sat_a, sat_b;
  logic [CW-1:0]      s_v, lim_v;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign tbl_we    = in_valid && in_ready && (in_data.req_type == rkspe_pkg::REQ_LOAD)
                     && ({1'b0, in_data.coef_row} < 5'(MS))
                     && ({1'b0, in_data.coef_col} < 5'(MS));
  assign tbl_waddr = AW'(in_data.coef_row) * AW'(MS) + AW'(in_data.coef_col);
  assign col_v     = rho_r ? (s_r - CW'(1)) : (k_r - CW'(1));
  assign tbl_raddr = AW'(i_r[SW-1:0]) * AW'(MS) + AW'(col_v[SW-1:0]);

  rkspe_ram #(.WIDTH(32), .DEPTH(rkspe_pkg::TBL_DEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (in_data.coef_value),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // Operands of the current product job.
  always_comb begin
    job_neg = 1'b0;
    if (mode_r == MODE_COEF) begin
      job_a    = c_r;
      job_b    = part_r[0] ? yi_r[i_r[SW-1:0]] : yr_r[i_r[SW-1:0]];
      job_dst  = part_r[0];
      job_sh30 = 1'b1;
    end else begin
      job_sh30 = 1'b0;
      job_dst  = part_r[1];
      case (part_r[1:0])
        2'd0: begin
          job_a = zr_r;
          job_b = tr_r;
        end
        2'd1: begin
          job_a   = zi_r;
          job_b   = ti_r;
          job_neg = 1'b1;
        end
        2'd2: begin
          job_a = zr_r;
          job_b = ti_r;
        end
        default: begin
          job_a = zi_r;
          job_b = tr_r;
        end
      endcase
    end
  end

  // Shared multiplier; squares split each value into a signed high and unsigned low half.
  always_comb begin
    sqv = part_r[2] ? ti_r : tr_r;
    if (state_r == ST_SQM) begin
      case (part_r[1:0])
        2'd0: begin
          mul_a = {{8{sqv[47]}}, sqv[47:24]};
          mul_b = {sqv[47], sqv[47:24]};
        end
        2'd1: begin
          mul_a = {{8{sqv[47]}}, sqv[47:24]};
          mul_b = {1'b0, sqv[23:0]};
        end
        default: begin
          mul_a = {8'd0, sqv[23:0]};
          mul_b = {1'b0, sqv[23:0]};
        end
      endcase
    end else begin
      mul_a = job_a;
      mul_b = (state_r == ST_P1) ? {job_b[47], job_b[47:24]} : {1'b0, job_b[23:0]};
    end
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    state_nxt = state_r;
    cplx_nxt  = cplx_r;
    rho_nxt   = rho_r;
    mode_nxt  = mode_r;
    part_nxt  = part_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    s_nxt     = s_r;
    zr_nxt    = zr_r;
    zi_nxt    = zi_r;
    c_nxt     = c_r;
    tr_nxt    = tr_r;
    ti_nxt    = ti_r;
    acc_nxt   = acc_r;
    aci_nxt   = aci_r;
    prod_nxt  = prod_r;
    lo_nxt    = lo_r;
    sum_nxt   = sum_r;
    sq_nxt    = sq_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    cnt_nxt   = cnt_r;
    flag_nxt  = flag_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    y_we  = 1'b0;
    y_wa  = k_r[SW-1:0];
    y_wdr = '0;
    y_wdi = '0;

    s_v   = ({1'b0, stage_cnt_r} > 6'(MS)) ? CW'(MS) : CW'(stage_cnt_r);
    lim_v = rho_r ? s_r : k_r;
    sh_v  = job_sh30 ? (sum_r >>> 30) : (sum_r >>> 20);
    term  = sh_v[63:0];
    sat_a = sat48(acc_r);
    sat_b = sat48(aci_r);

    sq_ext = {{40{prod_r[56]}}, prod_r};
    case (part_r[1:0])
      2'd0:    sq_add = sq_ext <<< 48;
      2'd1:    sq_add = sq_ext <<< 25;
      default: sq_add = sq_ext;
    endcase

    rem_sh = {rem_r[49:0], sq_r[95:94]};
    trial  = {2'b00, root_r, 2'b01};
    ge     = (rem_sh >= trial);

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.req_type == rkspe_pkg::REQ_REAL ||
              in_data.req_type == rkspe_pkg::REQ_CPLX) begin
            cplx_nxt  = (in_data.req_type == rkspe_pkg::REQ_CPLX);
            zr_nxt    = in_data.z_real;
            zi_nxt    = (in_data.req_type == rkspe_pkg::REQ_CPLX) ? in_data.z_imag : 32'sd0;
            flag_nxt  = 1'b0;
            state_nxt = ST_START;
          end
        end
      end
      ST_START: begin
        s_nxt   = s_v;
        y_we    = 1'b1;
        y_wa    = '0;
        y_wdr   = {{12{zr_r[31]}}, zr_r, 4'd0};
        y_wdi   = {{12{zi_r[31]}}, zi_r, 4'd0};
        acc_nxt = rkspe_pkg::Q24_ONE;
        aci_nxt = '0;
        i_nxt   = '0;
        k_nxt   = CW'(1);
        mode_nxt = MODE_COEF;
        part_nxt = '0;
        if (s_v == '0) begin
          state_nxt = ST_RHO;
        end else begin
          rho_nxt   = (s_v == CW'(1));
          state_nxt = ST_CRD;
        end
      end
      ST_CRD: begin
        state_nxt = ST_CLAT;
      end
      ST_CLAT: begin
        c_nxt     = tbl_rdata;
        part_nxt  = '0;
        state_nxt = ST_P0;
      end
      ST_P0: begin
        prod_nxt  = mul_p;
        state_nxt = ST_P1;
      end
      ST_P1: begin
        lo_nxt    = prod_r;
        prod_nxt  = mul_p;
        state_nxt = ST_P2;
      end
      ST_P2: begin
        sum_nxt   = {prod_r[55:0], 24'd0} + {{23{lo_r[56]}}, lo_r};
        state_nxt = ST_P3;
      end
      ST_P3: begin
        if (job_dst) begin
          aci_nxt = job_neg ? (aci_r - term) : (aci_r + term);
        end else begin
          acc_nxt = job_neg ? (acc_r - term) : (acc_r + term);
        end
        if (mode_r == MODE_COEF) begin
          if (!part_r[0]) begin
            part_nxt  = 3'd1;
            state_nxt = ST_P0;
          end else if (i_r + CW'(1) < lim_v) begin
            i_nxt     = i_r + CW'(1);
            state_nxt = ST_CRD;
          end else begin
            state_nxt = rho_r ? ST_RHO : ST_SAT;
          end
        end else begin
          if (part_r[1:0] == 2'd3) begin
            state_nxt = ST_ZWR;
          end else begin
            part_nxt  = part_r + 3'd1;
            state_nxt = ST_P0;
          end
        end
      end
      ST_SAT: begin
        tr_nxt    = sat_a[47:0];
        ti_nxt    = sat_b[47:0];
        flag_nxt  = flag_r | sat_a[48] | sat_b[48];
        acc_nxt   = '0;
        aci_nxt   = '0;
        mode_nxt  = MODE_Z;
        part_nxt  = '0;
        state_nxt = ST_P0;
      end
      ST_ZWR: begin
        y_we     = 1'b1;
        y_wdr    = sat_a[47:0];
        y_wdi    = sat_b[47:0];
        flag_nxt = flag_r | sat_a[48] | sat_b[48];
        acc_nxt  = rkspe_pkg::Q24_ONE;
        aci_nxt  = '0;
        i_nxt    = '0;
        mode_nxt = MODE_COEF;
        part_nxt = '0;
        if (k_r + CW'(1) < s_r) begin
          k_nxt = k_r + CW'(1);
        end else begin
          rho_nxt = 1'b1;
        end
        state_nxt = ST_CRD;
      end
      ST_RHO: begin
        tr_nxt   = sat_a[47:0];
        ti_nxt   = sat_b[47:0];
        flag_nxt = flag_r | sat_a[48] | sat_b[48];
        if (cplx_r) begin
          sq_nxt    = '0;
          part_nxt  = '0;
          state_nxt = ST_SQM;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SQM: begin
        prod_nxt  = mul_p;
        state_nxt = ST_SQA;
      end
      ST_SQA: begin
        sq_nxt = sq_r + sq_add;
        if (part_r[1:0] == 2'd2) begin
          if (part_r[2]) begin
            rem_nxt   = '0;
            root_nxt  = '0;
            cnt_nxt   = 6'd47;
            state_nxt = ST_SQRT;
          end else begin
            part_nxt  = 3'd4;
            state_nxt = ST_SQM;
          end
        end else begin
          part_nxt  = part_r + 3'd1;
          state_nxt = ST_SQM;
        end
      end
      ST_SQRT: begin
        // One result bit per cycle, taking the next two bits of the sum of squares.
        rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
        root_nxt = {root_r[46:0], ge};
        sq_nxt   = {sq_r[94:0], 2'b00};
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          if (cplx_r) begin
            out_data_nxt.result_value = root_r[47] ? rkspe_pkg::S48_MAX : root_r;
            out_data_nxt.saturated    = flag_r | root_r[47];
          end else begin
            out_data_nxt.result_value = tr_r;
            out_data_nxt.saturated    = flag_r;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      stage_cnt_r <= 5'd1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        stage_cnt_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cplx_r     <= cplx_nxt;
    rho_r      <= rho_nxt;
    mode_r     <= mode_nxt;
    part_r     <= part_nxt;
    k_r        <= k_nxt;
    i_r        <= i_nxt;
    s_r        <= s_nxt;
    zr_r       <= zr_nxt;
    zi_r       <= zi_nxt;
    c_r        <= c_nxt;
    tr_r       <= tr_nxt;
    ti_r       <= ti_nxt;
    acc_r      <= acc_nxt;
    aci_r      <= aci_nxt;
    prod_r     <= prod_nxt;
    lo_r       <= lo_nxt;
    sum_r      <= sum_nxt;
    sq_r       <= sq_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    cnt_r      <= cnt_nxt;
    flag_r     <= flag_nxt;
    out_data_r <= out_data_nxt;
    if (y_we) begin
      yr_r[y_wa] <= y_wdr;
      yi_r[y_wa] <= y_wdi;
    end
  end

`ifndef ASSERT_OFF
  a_eval_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.req_type == rkspe_pkg::REQ_REAL ||
     in_data.req_type == rkspe_pkg::REQ_CPLX)) |=> (state_r == ST_START))
    else $error("evaluation item did not start the sequencer");

  a_term_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CRD) |-> (i_r < (rho_r ? s_r : k_r)))
    else $error("coefficient term index beyond the current stage");

  a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CRD && !rho_r) |-> (k_r != '0 && k_r < s_r))
    else $error("stage index out of range");
`endif

endmodule
